@@ sv/swpwr_pkg.sv @@
// Shared types, codes and constants for the single-wire pulse-width receiver.
// Has no dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package swpwr_pkg;

    // Byte index wraps after this many bytes.
    localparam int unsigned BUFFER_BYTES = 256;
    localparam int unsigned BITS_PER_BYTE = 8;

    // Configuration address map (byte addresses, one register every 4 bytes).
    localparam int unsigned CFG_ADDR_W = 5;
    localparam int unsigned CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_START_LOW_MIN = 3'd0,
        REG_START_LOW_MAX = 3'd1,
        REG_PULSE_MIN     = 3'd2,
        REG_PULSE_SPLIT   = 3'd3,
        REG_PULSE_MAX     = 3'd4
    } reg_index_t;

    // Reset values of the timing registers, in microseconds.
    localparam logic [15:0] START_LOW_MIN_RST = 16'd3600;
    localparam logic [15:0] START_LOW_MAX_RST = 16'd4400;
    localparam logic [15:0] PULSE_MIN_RST     = 16'd40;
    localparam logic [15:0] PULSE_SPLIT_RST   = 16'd120;
    localparam logic [15:0] PULSE_MAX_RST     = 16'd200;

    // Input operation codes.
    typedef enum logic [1:0] {
        OP_WAKE    = 2'd0,
        OP_CAPTURE = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    // Reported phase codes.
    localparam logic [1:0] PHASE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_PRESTART = 2'd1;
    localparam logic [1:0] PHASE_RECEIVE = 2'd2;

    // Timing configuration seen by the decoder.
    typedef struct packed {
        logic [15:0] start_low_min;
        logic [15:0] start_low_max;
        logic [15:0] pulse_min;
        logic [15:0] pulse_split;
        logic [15:0] pulse_max;
    } cfg_t;

    // Receiver state carried from one transaction to the next.
    typedef struct packed {
        logic        prestart_flag;
        logic        receiving_flag;
        logic        falling_expected;
        logic [15:0] last_high_us;
        logic [2:0]  bit_position;
        logic [7:0]  partial_byte;
        logic [7:0]  byte_counter;
    } rx_state_t;

    // One result transaction.
    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic [1:0] phase;
        logic       expect_falling;
        logic       aborted;
    } result_t;

endpackage

@@ sv/swpwr_cfg_regs.sv @@
// APB-style register block holding the five timing thresholds.
// Depends on swpwr_pkg for the address map, reset values and cfg_t.
`timescale 1ns / 1ps

module swpwr_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swpwr_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [swpwr_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [swpwr_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready,
    output swpwr_pkg::cfg_t                     cfg
);
    import swpwr_pkg::*;

    cfg_t       cfg_reg;
    reg_index_t wr_index;
    logic       wr_en;

    assign pready   = 1'b1;
    assign wr_index = reg_index_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en    = psel && penable && pwrite && pready;

    // Register writes; addresses beyond the map are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_low_min <= START_LOW_MIN_RST;
            cfg_reg.start_low_max <= START_LOW_MAX_RST;
            cfg_reg.pulse_min     <= PULSE_MIN_RST;
            cfg_reg.pulse_split   <= PULSE_SPLIT_RST;
            cfg_reg.pulse_max     <= PULSE_MAX_RST;
        end else if (wr_en) begin
            case (wr_index)
                REG_START_LOW_MIN: cfg_reg.start_low_min <= pwdata[15:0];
                REG_START_LOW_MAX: cfg_reg.start_low_max <= pwdata[15:0];
                REG_PULSE_MIN:     cfg_reg.pulse_min     <= pwdata[15:0];
                REG_PULSE_SPLIT:   cfg_reg.pulse_split   <= pwdata[15:0];
                REG_PULSE_MAX:     cfg_reg.pulse_max     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back multiplexer.
    always_comb begin
        prdata = '0;
        case (wr_index)
            REG_START_LOW_MIN: prdata = {16'd0, cfg_reg.start_low_min};
            REG_START_LOW_MAX: prdata = {16'd0, cfg_reg.start_low_max};
            REG_PULSE_MIN:     prdata = {16'd0, cfg_reg.pulse_min};
            REG_PULSE_SPLIT:   prdata = {16'd0, cfg_reg.pulse_split};
            REG_PULSE_MAX:     prdata = {16'd0, cfg_reg.pulse_max};
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

@@ sv/swpwr_decode.sv @@
// Combinational next-state and result logic for one receiver transaction.
// Depends on swpwr_pkg for the state, configuration and result types.
`timescale 1ns / 1ps

module swpwr_decode (
    input  swpwr_pkg::cfg_t      cfg,
    input  swpwr_pkg::rx_state_t cur,
    input  logic [1:0]           operation,
    input  logic [15:0]          elapsed_us,
    output swpwr_pkg::rx_state_t nxt,
    output swpwr_pkg::result_t   res
);
    import swpwr_pkg::*;

    localparam logic [7:0] LAST_INDEX = 8'(BUFFER_BYTES - 1);

    logic       high_ok;
    logic       start_ok;
    logic       bit0_ok;
    logic       bit1_ok;
    logic       valid;
    logic       abort_now;
    logic [7:0] bit_mask;
    logic [7:0] new_byte;
    logic [2:0] next_pos;

    // Pulse classification against the thresholds.
    assign high_ok  = (elapsed_us > cfg.pulse_min) && (elapsed_us < cfg.pulse_max);
    assign start_ok = !((elapsed_us < cfg.start_low_min) || (elapsed_us > cfg.start_low_max));
    assign bit0_ok  = (cur.last_high_us < cfg.pulse_split) && (cur.last_high_us > cfg.pulse_min)
                   && (elapsed_us < cfg.pulse_max) && (elapsed_us > cfg.pulse_split);
    assign bit1_ok  = (cur.last_high_us > cfg.pulse_split) && (cur.last_high_us < cfg.pulse_max)
                   && (elapsed_us < cfg.pulse_split) && (elapsed_us > cfg.pulse_min);

    assign bit_mask = 8'(1) << cur.bit_position;
    assign new_byte = bit1_ok ? (cur.partial_byte | bit_mask) : (cur.partial_byte & ~bit_mask);
    assign next_pos = cur.bit_position + 3'd1;

    // State update, following the phase and the expected edge polarity.
    always_comb begin
        nxt       = cur;
        valid     = 1'b0;
        abort_now = 1'b0;
        case (op_t'(operation))
            OP_WAKE: begin
                nxt.prestart_flag    = 1'b1;
                nxt.falling_expected = 1'b0;
            end
            OP_TIMEOUT: begin
                if (cur.prestart_flag) begin
                    nxt.prestart_flag    = 1'b0;
                    nxt.receiving_flag   = 1'b0;
                    nxt.falling_expected = 1'b1;
                end
            end
            OP_CAPTURE: begin
                if (cur.falling_expected) begin
                    // Falling edge: arm from idle, or measure a high time.
                    if (!cur.receiving_flag && !cur.prestart_flag) begin
                        nxt.prestart_flag    = 1'b1;
                        nxt.falling_expected = 1'b0;
                    end else if (cur.prestart_flag && cur.receiving_flag) begin
                        if (high_ok) begin
                            nxt.last_high_us     = elapsed_us;
                            nxt.falling_expected = 1'b0;
                        end else begin
                            nxt.prestart_flag  = 1'b0;
                            nxt.receiving_flag = 1'b0;
                            nxt.last_high_us   = '0;
                            abort_now          = 1'b1;
                        end
                    end
                end else begin
                    // Rising edge: check the start pulse or decode a bit pair.
                    if (cur.prestart_flag && !cur.receiving_flag) begin
                        if (start_ok) begin
                            nxt.receiving_flag = 1'b1;
                        end else begin
                            nxt.prestart_flag = 1'b0;
                            abort_now         = 1'b1;
                        end
                    end else if (cur.prestart_flag && cur.receiving_flag) begin
                        if (bit0_ok || bit1_ok) begin
                            nxt.partial_byte = new_byte;
                            nxt.bit_position = next_pos;
                            if (next_pos == 3'd0) begin
                                valid            = 1'b1;
                                nxt.byte_counter = (cur.byte_counter == LAST_INDEX)
                                                 ? 8'd0 : cur.byte_counter + 8'd1;
                            end
                        end else begin
                            nxt.prestart_flag  = 1'b0;
                            nxt.receiving_flag = 1'b0;
                            abort_now          = 1'b1;
                        end
                    end
                    nxt.falling_expected = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Result fields; phase and expected edge come from the updated state, the byte index from the current one.
    always_comb begin
        res.byte_valid     = valid;
        res.byte_value     = valid ? new_byte : 8'd0;
        res.byte_index     = valid ? cur.byte_counter : 8'd0;
        res.phase          = nxt.receiving_flag ? PHASE_RECEIVE
                           : (nxt.prestart_flag ? PHASE_PRESTART : PHASE_IDLE);
        res.expect_falling = nxt.falling_expected;
        res.aborted        = abort_now;
    end

endmodule

@@ sv/single_wire_pulse_width_receiver_top.sv @@
// Top level of the single-wire pulse-width receiver: input register,
// receiver state, result register and the configuration block.
// Depends on swpwr_pkg, swpwr_cfg_regs and swpwr_decode.
//
//  Channel   Direction  Contents
//  s_axis    in         tuser: operation[1:0]; tdata: elapsed_us[15:0]
//  m_axis    out        tuser: byte_valid, phase, expect_falling, aborted;
//                       tdata: byte_value[7:0], byte_index[15:8]
//  APB       in/out     five 16-bit timing registers at byte addresses 0..16
//
// A transaction is decoded straight out of the input register, and its result
// is loaded into the result register on the edge at which it advances. The
// result is offered from the result register, and one transaction is taken
// every cycle while the result stream is not stalled. The receiver state
// updates when a transaction leaves the input register. A stalled result
// register holds the input register, which then deasserts s_tready. Reset is
// synchronous and active low and restores all thresholds.
`timescale 1ns / 1ps

module single_wire_pulse_width_receiver_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [15:0]                         s_tdata,  // [15:0] elapsed_us
    input  logic [1:0]                          s_tuser,  // [1:0] operation
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [15:0]                         m_tdata,  // [7:0] byte_value, [15:8] byte_index
    output logic [4:0]                          m_tuser,  // [0] byte_valid, [2:1] phase,
                                                          // [3] expect_falling, [4] aborted
    // Configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [swpwr_pkg::CFG_ADDR_W-1:0]    paddr,
    input  logic [swpwr_pkg::CFG_DATA_W-1:0]    pwdata,
    output logic [swpwr_pkg::CFG_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import swpwr_pkg::*;

    cfg_t        cfg;
    logic        in_valid_reg;
    logic [1:0]  in_op_reg;
    logic [15:0] in_elapsed_reg;
    rx_state_t   state_reg;
    rx_state_t   state_next;
    result_t     res_next;
    result_t     out_reg;
    logic        out_valid_reg;
    logic        advance;

    swpwr_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swpwr_decode u_decode (
        .cfg        (cfg),
        .cur        (state_reg),
        .operation  (in_op_reg),
        .elapsed_us (in_elapsed_reg),
        .nxt        (state_next),
        .res        (res_next)
    );

    // A transaction moves on when the result register is free or being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg      <= s_tuser;
            in_elapsed_reg <= s_tdata;
        end
    end

    // Receiver state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.prestart_flag    <= 1'b0;
            state_reg.receiving_flag   <= 1'b0;
            state_reg.falling_expected <= 1'b1;
            state_reg.last_high_us     <= '0;
            state_reg.bit_position     <= '0;
            state_reg.partial_byte     <= '0;
            state_reg.byte_counter     <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.byte_index, out_reg.byte_value};
    assign m_tuser  = {out_reg.aborted, out_reg.expect_falling, out_reg.phase,
                       out_reg.byte_valid};

    // A completed byte is only reported while receiving.
    a_byte_in_receive: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.byte_valid) |-> (out_reg.phase == PHASE_RECEIVE))
        else $error("byte reported outside the receiving phase");

    // An abort always leaves the receiver idle and waiting for a falling edge.
    a_abort_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_reg.aborted) |->
        ((out_reg.phase == PHASE_IDLE) && out_reg.expect_falling && !out_reg.byte_valid))
        else $error("abort did not return the receiver to idle");

    // Receiving implies the receiver was armed.
    a_recv_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.receiving_flag |-> state_reg.prestart_flag)
        else $error("receiving without prestart");

    // State changes only when a transaction passes through the decoder.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!$past(advance) && $past(aresetn)) |-> $stable(state_reg))
        else $error("receiver state changed without a transaction");

    // A byte completes exactly when the bit position wraps to zero.
    a_byte_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_next.byte_valid) |=> (state_reg.bit_position == 3'd0))
        else $error("byte completed without bit position wrap");

endmodule
